@@ rtl/ellipse_column_rasterizer_unit_macros.svh @@
// assertion macros used by the ellipse column rasterizer back end
`ifndef ELLIPSE_COLUMN_RASTERIZER_UNIT_MACROS_SVH
`define ELLIPSE_COLUMN_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ECR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ECR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ecr_pkg.sv @@
// shared types, constants and the percent-to-cell scaling function
package ecr_pkg;

   localparam int POS_W   = 7;   // center coordinates
   localparam int RAD_W   = 7;   // horizontal radius
   localparam int V_W     = 5;   // vertical radius
   localparam int OFF_W   = 8;   // column offset
   localparam int CELL_W  = 8;   // output cell coordinates
   localparam int GRID_W  = 8;   // grid size registers
   localparam int VSQ_W   = 2 * V_W;
   localparam int HSQ_W   = 2 * RAD_W;
   localparam int ROOT_W  = V_W;
   localparam int CNT_W   = ROOT_W + 1;
   localparam int PROD_W  = 18;  // (coord + center) * grid, signed
   localparam int MAG_W   = 16;
   localparam int RECIP_W = 17;
   localparam int QUEUE_DEPTH = 2;

   // fixed-point scale of the height ratio, a power of two
   localparam int FRACTION_SCALE = 256;
   localparam int FRACTION_SHIFT = 8;

   // floor(m / 100) == (m * DIV_RECIP) >> DIV_SHIFT for all m below 2^16
   localparam logic [RECIP_W-1:0] DIV_RECIP = 17'd83887;
   localparam int DIV_SHIFT = 23;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;
   localparam logic [GRID_W-1:0] GRID_RESET = 8'd32;

   typedef struct packed {
      logic [POS_W-1:0]        cx;
      logic [POS_W-1:0]        cy;
      logic [RAD_W-1:0]        h;
      logic [V_W-1:0]          v;
      logic signed [OFF_W-1:0] x;
      logic [RAD_W-1:0]        ax;
      logic                    h_zero;
   } job_type;

   // signed product / 100 truncated toward zero, wrapped to the cell width
   function automatic logic [CELL_W-1:0] span_div(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0]          mag;
      logic [MAG_W+RECIP_W-1:0]   scaled;
      logic [CELL_W-1:0]          quo;
      mag    = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      scaled = (MAG_W+RECIP_W)'(mag[MAG_W-1:0]) * (MAG_W+RECIP_W)'(DIV_RECIP);
      quo    = scaled[DIV_SHIFT +: CELL_W];
      return p[PROD_W-1] ? CELL_W'(-quo) : quo;
   endfunction

endpackage

@@ rtl/ecr_req_if.sv @@
// request channel: one ellipse column per word
interface ecr_req_if;
   import ecr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [POS_W-1:0]        center_x;
   logic [POS_W-1:0]        center_y;
   logic [RAD_W-1:0]        h_radius;
   logic [V_W-1:0]          v_radius;
   logic signed [OFF_W-1:0] column_offset;

   modport source (output valid, center_x, center_y, h_radius, v_radius, column_offset,
                   input ready);
   modport sink (input valid, center_x, center_y, h_radius, v_radius, column_offset,
                 output ready);
endinterface

@@ rtl/ecr_rsp_if.sv @@
// response channel: one grid cell per word
interface ecr_rsp_if;
   import ecr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_x;
   logic signed [CELL_W-1:0] cell_y;
   logic                     last_cell;

   modport source (output valid, cell_x, cell_y, last_cell, input ready);
   modport sink (input valid, cell_x, cell_y, last_cell, output ready);
endinterface

@@ rtl/ecr_front.sv @@
// front end: takes request words, clamps the vertical radius and the offset, pushes jobs
module ecr_front #(
   parameter int MAX_V_RADIUS = 31
) (
   ecr_req_if.sink          req_chan,
   input  logic             queue_full,
   output logic             push,
   output ecr_pkg::job_type job
);
   import ecr_pkg::*;

   localparam logic [V_W-1:0] V_MAX = V_W'(MAX_V_RADIUS);

   logic signed [OFF_W-1:0] h_pos;
   logic signed [OFF_W-1:0] h_neg;
   logic signed [OFF_W-1:0] x_clamped;

   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;

   always_comb begin
      h_pos = $signed({1'b0, req_chan.h_radius});
      h_neg = -h_pos;
      x_clamped = req_chan.column_offset;
      if (x_clamped > h_pos) begin
         x_clamped = h_pos;
      end else if (x_clamped < h_neg) begin
         x_clamped = h_neg;
      end
      job.cx = req_chan.center_x;
      job.cy = req_chan.center_y;
      job.h = req_chan.h_radius;
      job.v = (req_chan.v_radius > V_MAX) ? V_MAX : req_chan.v_radius;
      job.x = x_clamped;
      job.ax = x_clamped[OFF_W-1] ? RAD_W'(-x_clamped) : RAD_W'(x_clamped);
      job.h_zero = (req_chan.h_radius == '0);
   end

endmodule

@@ rtl/ecr_queue.sv @@
// short job queue between front end and back end
module ecr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ecr_pkg::job_type push_job,
   input  logic             pop,
   output ecr_pkg::job_type head_job,
   output logic             head_valid,
   output logic             full
);
   import ecr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/ecr_divider.sv @@
// restoring divider, one quotient bit per cycle
module ecr_divider #(
   parameter int QUOT_W = 10,
   parameter int DEN_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DEN_W+QUOT_W-1:0]   num,
   input  logic [DEN_W-1:0]          den,
   output logic                      busy,
   output logic                      done,
   output logic [QUOT_W-1:0]         quot
);
   localparam int REM_W = DEN_W + QUOT_W;
   localparam int STEP_W = $clog2(QUOT_W + 1);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic              take;

   assign busy = (step_ff != '0);
   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      done_in = 1'b0;
      take = (rem_ff >= dsh_ff);
      if (start) begin
         rem_in = num;
         dsh_in = REM_W'(den) << (QUOT_W - 1);
         quot_in = '0;
         step_in = STEP_W'(QUOT_W);
      end else if (step_ff != '0) begin
         if (take) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], take};
         dsh_in = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quot_ff <= quot_in;
   end

endmodule

@@ rtl/ecr_back.sv @@
// back end: half-height, square root and cell emission for one column
`include "ellipse_column_rasterizer_unit_macros.svh"

module ecr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ecr_pkg::job_type            job,
   input  logic                        job_valid,
   output logic                        job_pop,
   input  logic [ecr_pkg::GRID_W-1:0]  grid_width,
   input  logic [ecr_pkg::GRID_W-1:0]  grid_height,
   ecr_rsp_if.source                   rsp_chan
);
   import ecr_pkg::*;

   localparam int SCALE_W = $clog2(FRACTION_SCALE + 1);
   localparam int QUOT_W = (SCALE_W > VSQ_W) ? SCALE_W : VSQ_W;
   localparam int DEN_W = HSQ_W;
   localparam int REM_W = DEN_W + QUOT_W;
   localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(FRACTION_SCALE);

   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_SQUARE     = 10'b0000000010,
      S_RATIO_GO   = 10'b0000000100,
      S_RATIO_WAIT = 10'b0000001000,
      S_HEIGHT     = 10'b0000010000,
      S_YSQ        = 10'b0000100000,
      S_ROOT       = 10'b0001000000,
      S_SETUP      = 10'b0010000000,
      S_PX         = 10'b0100000000,
      S_EMIT       = 10'b1000000000
   } state_type;

   state_type                state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [HSQ_W-1:0]         axsq_ff, axsq_in;
   logic [HSQ_W-1:0]         hsq_ff, hsq_in;
   logic [VSQ_W-1:0]         vsq_ff, vsq_in;
   logic [SCALE_W-1:0]       ratio_ff, ratio_in;
   logic [REM_W-1:0]         hnum_ff, hnum_in;
   logic [VSQ_W-1:0]         ysq_ff, ysq_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [ROOT_W-1:0]        rbit_ff, rbit_in;
   logic signed [PROD_W-1:0] p_ff, p_in;
   logic signed [PROD_W-1:0] pxp_ff, pxp_in;
   logic [CELL_W-1:0]        px_ff, px_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     out_valid_ff, out_valid_in;
   logic [CELL_W-1:0]        cell_x_ff, cell_x_in;
   logic [CELL_W-1:0]        cell_y_ff, cell_y_in;
   logic                     last_ff, last_in;

   logic                     div_start;
   logic [REM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_busy;
   logic                     div_done;
   logic [QUOT_W-1:0]        div_quot;

   logic                     out_load;
   logic                     cell_done;
   logic [ROOT_W-1:0]        trial;
   logic [VSQ_W-1:0]         trial_sq;
   logic signed [8:0]        ydiff;
   logic signed [8:0]        xsum;

   ecr_divider #(
      .QUOT_W (QUOT_W),
      .DEN_W  (DEN_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.cell_x = $signed(cell_x_ff);
   assign rsp_chan.cell_y = $signed(cell_y_ff);
   assign rsp_chan.last_cell = last_ff;

   assign job_pop = (state_ff == S_IDLE) && job_valid;
   assign out_load = (state_ff == S_EMIT) && (!out_valid_ff || rsp_chan.ready);
   assign cell_done = out_load && (left_ff == '0);

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      axsq_in = axsq_ff;
      hsq_in = hsq_ff;
      vsq_in = vsq_ff;
      ratio_in = ratio_ff;
      hnum_in = hnum_ff;
      ysq_in = ysq_ff;
      root_in = root_ff;
      rbit_in = rbit_ff;
      p_in = p_ff;
      pxp_in = pxp_ff;
      px_in = px_ff;
      left_in = left_ff;
      cell_x_in = cell_x_ff;
      cell_y_in = cell_y_ff;
      last_in = last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      div_start = 1'b0;
      div_num = REM_W'(axsq_ff) * REM_W'(SCALE_MAX);
      div_den = hsq_ff;
      trial = root_ff | rbit_ff;
      trial_sq = VSQ_W'(trial) * VSQ_W'(trial);
      ydiff = $signed({2'b00, job_ff.cy}) - $signed({4'b0000, root_ff});
      xsum = 9'($signed(job_ff.x)) + $signed({2'b00, job_ff.cx});

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in = job;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            axsq_in = HSQ_W'(job_ff.ax) * HSQ_W'(job_ff.ax);
            hsq_in = HSQ_W'(job_ff.h) * HSQ_W'(job_ff.h);
            vsq_in = VSQ_W'(job_ff.v) * VSQ_W'(job_ff.v);
            state_in = S_RATIO_GO;
         end
         S_RATIO_GO: begin
            // zero horizontal radius gives the full height
            if (job_ff.h_zero) begin
               ratio_in = '0;
               state_in = S_HEIGHT;
            end else begin
               div_start = 1'b1;
               state_in = S_RATIO_WAIT;
            end
         end
         S_RATIO_WAIT: begin
            if (div_done) begin
               ratio_in = (div_quot > QUOT_W'(SCALE_MAX)) ? SCALE_MAX
                                                           : div_quot[SCALE_W-1:0];
               state_in = S_HEIGHT;
            end
         end
         S_HEIGHT: begin
            hnum_in = REM_W'(vsq_ff) * REM_W'(SCALE_MAX - ratio_ff);
            state_in = S_YSQ;
         end
         S_YSQ: begin
            ysq_in = VSQ_W'(hnum_ff >> FRACTION_SHIFT);
            root_in = '0;
            rbit_in = {1'b1, {(ROOT_W-1){1'b0}}};
            state_in = S_ROOT;
         end
         S_ROOT: begin
            // one root bit per cycle, msb first
            if (trial_sq <= ysq_ff) begin
               root_in = trial;
            end
            rbit_in = rbit_ff >> 1;
            if (rbit_ff[0]) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            p_in = PROD_W'(ydiff) * PROD_W'($signed({1'b0, grid_height}));
            pxp_in = PROD_W'(xsum) * PROD_W'($signed({1'b0, grid_width}));
            left_in = {root_ff, 1'b0};
            state_in = S_PX;
         end
         S_PX: begin
            px_in = span_div(pxp_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               cell_x_in = px_ff;
               cell_y_in = span_div(p_ff);
               last_in = (left_ff == '0);
               // next row adds one grid height to the running product
               p_in = p_ff + PROD_W'($signed({1'b0, grid_height}));
               left_in = left_ff - 1'b1;
               if (left_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      axsq_ff <= axsq_in;
      hsq_ff <= hsq_in;
      vsq_ff <= vsq_in;
      ratio_ff <= ratio_in;
      hnum_ff <= hnum_in;
      ysq_ff <= ysq_in;
      root_ff <= root_in;
      rbit_ff <= rbit_in;
      p_ff <= p_in;
      pxp_ff <= pxp_in;
      px_ff <= px_in;
      left_ff <= left_in;
      cell_x_ff <= cell_x_in;
      cell_y_ff <= cell_y_in;
      last_ff <= last_in;
   end

   `ECR_ASSERT_NOW(a_div_start_idle, clock, reset, div_start, !div_busy, "divider restarted while busy")
   `ECR_ASSERT_NOW(a_ratio_bound, clock, reset, (state_ff == S_HEIGHT), (ratio_ff <= SCALE_MAX), "ratio above scale")
   `ECR_ASSERT_NOW(a_root_bound, clock, reset, (state_ff == S_SETUP), (root_ff <= job_ff.v), "root above vertical radius")
   `ECR_ASSERT_NEXT(a_last_ends_run, clock, reset, cell_done, (state_ff == S_IDLE), "run continued after last cell")

endmodule

@@ rtl/ellipse_column_rasterizer_unit.sv @@
// top level: grid registers, request front end, job queue and cell back end
//
// Takes one ellipse column per request word on req_chan (center, radii and
// column offset in percent) and returns the grid cells of that column on
// rsp_chan, lowest row first, with last_cell set on the final cell.
// grid_width (index 0) and grid_height (index 1) are written through the
// csr_ port; both reset to 32. The user must write them only while no
// column is in flight; the block itself does not enforce this.
// Into an idle block the first cell follows one pass through the ratio
// divider, whose quotient width is 10 at a scale of 256, then a five-step
// square root. A zero horizontal radius skips the divider.
// The 2*y1+1 cells then go out one per cycle while rsp_chan is ready;
// a full column has 63 cells. A two-word job queue lets the next request
// be taken while a column is still being emitted. When rsp_chan stalls,
// the output register holds its word and the back end waits; the queue
// fills and req_chan.ready drops. Reset empties the queue and the output
// register.
module ellipse_column_rasterizer_unit #(
   parameter int MAX_V_RADIUS = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   ecr_req_if.sink                       req_chan,
   ecr_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [ecr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ecr_pkg::GRID_W-1:0]    csr_write_data
);
   import ecr_pkg::*;

   logic [GRID_W-1:0] grid_width_ff, grid_width_in;
   logic [GRID_W-1:0] grid_height_ff, grid_height_in;
   job_type           front_job;
   job_type           head_job;
   logic              push;
   logic              queue_full;
   logic              head_valid;
   logic              pop;

   always_comb begin
      grid_width_in = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in = csr_write_data;
            CSR_GRID_HEIGHT: grid_height_in = csr_write_data;
            default: begin
               grid_width_in = grid_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_RESET;
         grid_height_ff <= GRID_RESET;
      end else begin
         grid_width_ff <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   ecr_front #(
      .MAX_V_RADIUS (MAX_V_RADIUS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   ecr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (front_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   ecr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (head_job),
      .job_valid   (head_valid),
      .job_pop     (pop),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule
